// ===== hdl/slri_pkg.sv =====
// ----------------------------------------------------------------------------
// slri_pkg
// shared types, codes and sizes for the sorted list insert/remove block
// ----------------------------------------------------------------------------
package slri_pkg;

    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int CAPACITY_DEF = 16;

    // command codes
    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic                     do_insert;
        logic                     do_remove;
        logic signed [DATA_W-1:0] item;
    } t_slri_bcast;

endpackage

// ===== hdl/slri_cell.sv =====
// ----------------------------------------------------------------------------
// slri_cell
// one list entry: compares against the broadcast word, shifts with neighbors
// ----------------------------------------------------------------------------
module slri_cell
    import slri_pkg::*;
(
    input  logic                     i_clk,
    input  t_slri_bcast              i_bcast,
    input  logic                     i_occupied,
    input  logic                     i_left_cond,
    input  logic signed [DATA_W-1:0] i_left_data,
    input  logic signed [DATA_W-1:0] i_right_data,
    output logic                     o_cond,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_data,
    output logic signed [DATA_W-1:0] o_next
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     ge;
    logic                     eq;

    assign ge     = (r_data >= i_bcast.item);
    assign eq     = (r_data == i_bcast.item);
    // this entry and all to its right are at or past the insert point
    assign o_cond = !i_occupied || ge;
    // first entry at or past the insert point, holding an equal value
    assign o_hit  = o_cond && !i_left_cond && i_occupied && eq;
    assign o_data = r_data;
    assign o_next = n_data;

    always_comb begin
        n_data = r_data;
        if (i_bcast.do_insert) begin
            if (i_left_cond) begin
                n_data = i_left_data;
            end else if (o_cond) begin
                n_data = i_bcast.item;
            end
        end else if (i_bcast.do_remove) begin
            if (o_cond) begin
                n_data = i_right_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== hdl/sorted_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// bounded sorted list of signed words built as a row of shifting cells
// ----------------------------------------------------------------------------
// The block takes one command word per clock while o_stall is low and returns
// one result word per command, registered in the cycle after acceptance.
// Every cell of the row compares its entry with the broadcast item in the same
// cycle and takes its left or right neighbor's entry, so an insert or a remove
// shifts the row at once whatever the list fill; that row of compares and the found
// reduction across it set the cycle. There is a single result register:
// while its word waits to be taken the command side stalls, and a new command
// enters in the same cycle that the waiting result is taken. Inserts
// place the item in front of the first entry greater than or equal to it and
// are refused with the full status when CAPACITY entries are stored. Removes
// delete one equal entry or report a miss. Each result carries the status,
// the count after the step (low 5 bits) and the smallest stored item, 0 when
// the list is empty. Entries at or beyond the count are don't-care storage.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove
    import slri_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command side
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [0:0]               i_cmd,
    input  logic signed [DATA_W-1:0] i_item,
    // result side
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COUNT_W-1:0]       o_count,
    output logic signed [DATA_W-1:0] o_head_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // list fill
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;

    // result register
    logic                      r_valid;
    logic [STATUS_W-1:0]       r_status;
    logic [CNT_W-1:0]          r_res_count;
    logic signed [DATA_W-1:0]  r_head;

    logic                      accept;
    logic                      full;
    logic                      found;
    t_status                   status;
    t_slri_bcast               bcast;

    // per-cell wires of the row
    logic [CAPACITY-1:0]       cond;
    logic [CAPACITY-1:0]       hit;
    logic signed [DATA_W-1:0]  data [CAPACITY];
    logic signed [DATA_W-1:0]  next [CAPACITY];

    // count field carries the low bits of the fill, zero-extended if narrower
    logic [CNT_W+COUNT_W-1:0]  count_ext;

    // hold off new commands only while an untaken result sits in the register
    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign full  = (r_count == CNT_W'(CAPACITY));
    // a remove matches if the first entry at or past the item equals it
    assign found = |hit;

    always_comb begin
        bcast.item      = i_item;
        bcast.do_insert = accept && (i_cmd == CMD_INSERT) && !full;
        bcast.do_remove = accept && (i_cmd == CMD_REMOVE) && found;
    end

    // cell row: each cell sees its neighbors' entries and the left cell's
    // insert-point flag; the ends are tied off
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     left_cond;
        logic signed [DATA_W-1:0] left_data;
        logic signed [DATA_W-1:0] right_data;
        logic                     occupied;

        if (g == 0) begin : g_first
            assign left_cond = 1'b0;
            assign left_data = '0;
        end else begin : g_mid
            assign left_cond = cond[g-1];
            assign left_data = data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_inner
            assign right_data = data[g+1];
        end

        assign occupied = (CNT_W'(g) < r_count);

        slri_cell u_cell (
            .i_clk        (i_clk),
            .i_bcast      (bcast),
            .i_occupied   (occupied),
            .i_left_cond  (left_cond),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .o_cond       (cond[g]),
            .o_hit        (hit[g]),
            .o_data       (data[g]),
            .o_next       (next[g])
        );
    end

    // status and next fill
    always_comb begin
        n_count = r_count;
        status  = ST_DONE;
        case (i_cmd)
            CMD_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (!found) begin
                    status = ST_MISS;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    // fill counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, head taken from the first cell's next entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_res_count <= n_count;
            r_head      <= (n_count != '0) ? next[0] : '0;
        end
    end

    assign count_ext   = {{COUNT_W{1'b0}}, r_res_count};
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_count     = count_ext[COUNT_W-1:0];
    assign o_head_item = r_head;

endmodule
